/* design/satq_pkg.sv */
// ----------------------------------------------------------------------------
// satq_pkg
// shared constants and codes for the summed-area table query core
// ----------------------------------------------------------------------------
package satq_pkg;

    // default table geometry
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLUMNS = 64;

    // field widths
    localparam int COUNT_W   = 7;   // row_count / column_count registers
    localparam int ELEM_W    = 16;  // element_value
    localparam int POS_W     = 6;   // query corner fields
    localparam int RUN_W     = 22;  // running row sum
    localparam int SUM_W     = 28;  // table entries and rectangle_sum
    localparam int IN_DATA_W = 40;  // packed input tdata
    localparam int OUT_DATA_W = 32; // packed output tdata

    // operation codes carried on the input tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NOT_LOADED = 2'd1,
        STATUS_BAD_BOUNDS = 2'd2
    } status_t;

endpackage

/* design/summed_area_table_query_core.sv */
// ----------------------------------------------------------------------------
// summed_area_table_query_core
// integral image builder with rectangle-sum queries
// ----------------------------------------------------------------------------
// Load items (tuser = load) deliver matrix elements row-major; each one builds
// an integral entry from the element, the running row sum and the entry above
// it, using a single-port table memory and one shared 28-bit add/subtract
// unit. A load item runs through accept, read of the entry above while the
// shared unit updates the running row sum, and write.
// A query item (tuser = query) with a complete table and good bounds runs
// through accept, first table read, four accumulate steps and result hand-off:
// four table reads through the one memory port, each folded into the
// accumulator by the shared adder, then the result register. An error query
// goes from the accept straight to the result hand-off. The block takes one
// item at a time; a result waiting on the output does not stop further loads
// or the work of the next query, only its final hand-off. The table memory
// needs no clearing. Writing either count register restarts loading from
// row 0, column 0.
module summed_area_table_query_core #(
    parameter int MAX_ROWS    = satq_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = satq_pkg::DEF_MAX_COLUMNS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input item stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // element_value[15:0], top_row[21:16], left_column[27:22],
    // bottom_row[33:28], right_column[39:34]
    input  logic [satq_pkg::IN_DATA_W-1:0]   s_tdata,
    // operation[0]
    input  logic                             s_tuser,
    // result item stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // rectangle_sum[27:0], zero pad[31:28]
    output logic [satq_pkg::OUT_DATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [1:0]                       m_tuser,
    // configuration write port
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [satq_pkg::COUNT_W-1:0]     cfg_data
);

    // index widths follow the table geometry
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int SW = satq_pkg::SUM_W;
    localparam int PW = satq_pkg::POS_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_Q_RD0,
        ST_Q_ACC1,
        ST_Q_ACC2,
        ST_Q_ACC3,
        ST_Q_ACC4,
        ST_FIN
    } state_t;

    state_t state_reg;

    // configuration
    logic [satq_pkg::COUNT_W-1:0] row_count_reg;
    logic [satq_pkg::COUNT_W-1:0] column_count_reg;
    logic [RW-1:0]                last_row;
    logic [CW-1:0]                last_col;

    // load position and running row sum
    logic [RW-1:0]                load_row_reg;
    logic [CW-1:0]                load_col_reg;
    logic [satq_pkg::RUN_W-1:0]   run_reg;
    logic [satq_pkg::ELEM_W-1:0]  elem_reg;
    logic                         complete_reg;

    // query operands
    logic [RW-1:0]                qb_reg;
    logic [RW-1:0]                qt1_reg;
    logic [CW-1:0]                qr_reg;
    logic [CW-1:0]                ql1_reg;
    logic                         tz_reg;
    logic                         lz_reg;
    logic [SW-1:0]                acc_reg;
    satq_pkg::status_t            status_reg;

    // output register
    logic                         m_valid_reg;
    logic [SW-1:0]                m_sum_reg;
    satq_pkg::status_t            m_status_reg;

    // table memory, single port, registered read
    logic [SW-1:0]                mem [DEPTH];
    logic [SW-1:0]                rd_data_reg;
    logic                         mem_we;
    logic [RW-1:0]                mem_row;
    logic [CW-1:0]                mem_col;
    logic [AW-1:0]                mem_addr;

    // shared add/subtract unit
    logic [SW-1:0]                alu_a;
    logic [SW-1:0]                alu_x;
    logic                         alu_sub;
    logic [SW-1:0]                acc_next;

    // input field views
    logic [satq_pkg::ELEM_W-1:0]  in_elem;
    logic [PW-1:0]                in_top;
    logic [PW-1:0]                in_left;
    logic [PW-1:0]                in_bottom;
    logic [PW-1:0]                in_right;
    logic                         in_accept;
    satq_pkg::status_t            q_status;
    logic                         out_free;

    assign in_elem   = s_tdata[15:0];
    assign in_top    = s_tdata[21:16];
    assign in_left   = s_tdata[27:22];
    assign in_bottom = s_tdata[33:28];
    assign in_right  = s_tdata[39:34];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(satq_pkg::OUT_DATA_W - SW){1'b0}}, m_sum_reg};
    assign m_tuser  = m_status_reg;

    // counts in use, clamped: zero acts as one, large acts as the maximum
    always_comb
    begin
        int rc;
        int cc;
        rc = int'(row_count_reg);
        cc = int'(column_count_reg);
        if (rc == 0)
            last_row = '0;
        else if (rc > MAX_ROWS)
            last_row = RW'(MAX_ROWS - 1);
        else
            last_row = RW'(rc - 1);
        if (cc == 0)
            last_col = '0;
        else if (cc > MAX_COLUMNS)
            last_col = CW'(MAX_COLUMNS - 1);
        else
            last_col = CW'(cc - 1);
    end

    // query status, missing table before bad bounds
    always_comb
    begin
        if (!complete_reg)
            q_status = satq_pkg::STATUS_NOT_LOADED;
        else if (in_top > in_bottom || in_left > in_right
                 || 32'(in_bottom) > 32'(last_row) || 32'(in_right) > 32'(last_col))
            q_status = satq_pkg::STATUS_BAD_BOUNDS;
        else
            q_status = satq_pkg::STATUS_OK;
    end

    // memory address and shared unit operands per sequencer step
    always_comb
    begin
        mem_we  = 1'b0;
        mem_row = '0;
        mem_col = '0;
        alu_a   = acc_reg;
        alu_x   = rd_data_reg;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_LD_RD:
            begin
                // entry above; row zero sees the border instead
                mem_row = (load_row_reg == '0) ? '0 : load_row_reg - 1'b1;
                mem_col = load_col_reg;
                // running row sum picks up the element
                alu_a   = {{(SW - satq_pkg::RUN_W){run_reg[satq_pkg::RUN_W-1]}}, run_reg};
                alu_x   = {{(SW - satq_pkg::ELEM_W){elem_reg[satq_pkg::ELEM_W-1]}},
                           elem_reg};
            end
            ST_LD_WR:
            begin
                mem_we  = 1'b1;
                mem_row = load_row_reg;
                mem_col = load_col_reg;
                alu_a   = {{(SW - satq_pkg::RUN_W){run_reg[satq_pkg::RUN_W-1]}}, run_reg};
                alu_x   = (load_row_reg == '0) ? '0 : rd_data_reg;
            end
            ST_Q_RD0:
            begin
                mem_row = qb_reg;
                mem_col = qr_reg;
            end
            ST_Q_ACC1:
            begin
                mem_row = qt1_reg;
                mem_col = qr_reg;
            end
            ST_Q_ACC2:
            begin
                mem_row = qb_reg;
                mem_col = ql1_reg;
                alu_x   = tz_reg ? '0 : rd_data_reg;
                alu_sub = 1'b1;
            end
            ST_Q_ACC3:
            begin
                mem_row = qt1_reg;
                mem_col = ql1_reg;
                alu_x   = lz_reg ? '0 : rd_data_reg;
                alu_sub = 1'b1;
            end
            ST_Q_ACC4:
            begin
                alu_x   = (tz_reg || lz_reg) ? '0 : rd_data_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign mem_addr = AW'(32'(mem_row) * MAX_COLUMNS + 32'(mem_col));
    assign acc_next = alu_sub ? (alu_a - alu_x) : (alu_a + alu_x);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= acc_next;
        rd_data_reg <= mem[mem_addr];
    end

    // sequencer, load position, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            row_count_reg    <= satq_pkg::COUNT_W'(64);
            column_count_reg <= satq_pkg::COUNT_W'(64);
            load_row_reg     <= '0;
            load_col_reg     <= '0;
            run_reg          <= '0;
            elem_reg         <= '0;
            complete_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            m_sum_reg        <= '0;
            m_status_reg     <= satq_pkg::STATUS_OK;
            qb_reg           <= '0;
            qt1_reg          <= '0;
            qr_reg           <= '0;
            ql1_reg          <= '0;
            tz_reg           <= 1'b0;
            lz_reg           <= 1'b0;
            acc_reg          <= '0;
            status_reg       <= satq_pkg::STATUS_OK;
        end
        else
        begin
            // the hand-off state reloads the output register itself
            if (m_valid_reg && m_tready && state_reg != ST_FIN)
                m_valid_reg <= 1'b0;

            // any count write restarts loading
            if (cfg_we)
            begin
                if (cfg_index == satq_pkg::REG_ROW_COUNT)
                    row_count_reg <= cfg_data;
                else
                    column_count_reg <= cfg_data;
                load_row_reg <= '0;
                load_col_reg <= '0;
                run_reg      <= '0;
                complete_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (s_tuser == satq_pkg::OP_LOAD)
                        begin
                            // a load after completion starts a new table; position
                            // and running sum are back at zero by then
                            elem_reg     <= in_elem;
                            complete_reg <= 1'b0;
                            state_reg    <= ST_LD_RD;
                        end
                        else
                        begin
                            qb_reg     <= RW'(in_bottom);
                            qr_reg     <= CW'(in_right);
                            qt1_reg    <= (in_top == '0) ? '0 : RW'(in_top - 1'b1);
                            ql1_reg    <= (in_left == '0) ? '0 : CW'(in_left - 1'b1);
                            tz_reg     <= (in_top == '0);
                            lz_reg     <= (in_left == '0);
                            acc_reg    <= '0;
                            status_reg <= q_status;
                            if (q_status == satq_pkg::STATUS_OK)
                                state_reg <= ST_Q_RD0;
                            else
                                state_reg <= ST_FIN;
                        end
                    end
                end
                ST_LD_RD:
                begin
                    run_reg   <= acc_next[satq_pkg::RUN_W-1:0];
                    state_reg <= ST_LD_WR;
                end
                ST_LD_WR:
                begin
                    // entry written this cycle, advance row-major
                    if (load_col_reg == last_col)
                    begin
                        load_col_reg <= '0;
                        run_reg      <= '0;
                        if (load_row_reg == last_row)
                        begin
                            load_row_reg <= '0;
                            complete_reg <= 1'b1;
                        end
                        else
                            load_row_reg <= load_row_reg + 1'b1;
                    end
                    else
                        load_col_reg <= load_col_reg + 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_Q_RD0:
                begin
                    state_reg <= ST_Q_ACC1;
                end
                ST_Q_ACC1:
                begin
                    acc_reg   <= acc_next;
                    state_reg <= ST_Q_ACC2;
                end
                ST_Q_ACC2:
                begin
                    acc_reg   <= acc_next;
                    state_reg <= ST_Q_ACC3;
                end
                ST_Q_ACC3:
                begin
                    acc_reg   <= acc_next;
                    state_reg <= ST_Q_ACC4;
                end
                ST_Q_ACC4:
                begin
                    acc_reg   <= acc_next;
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    // hand the result over once the output register is free
                    if (out_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_sum_reg    <= acc_reg;
                        m_status_reg <= status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* verif/summed_area_table_query_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// summed_area_table_query_core_test
// self-checking bench for the integral image build and rectangle-sum queries
// ----------------------------------------------------------------------------
// Load items and query items go in over the input stream with random gaps.
// A behavioral integral table in the bench follows every accepted item and
// queues the expected rectangle sum and status for each query. Results
// leave under random back-pressure and are checked in order. Count
// registers are only rewritten once the block has drained.
module summed_area_table_query_core_test;

    localparam int          MAX_R         = satq_pkg::DEF_MAX_ROWS;
    localparam int          MAX_C         = satq_pkg::DEF_MAX_COLUMNS;
    localparam int unsigned RANDOM_ITEMS  = 750;
    // slowest item is a good query; allow time for the last one
    localparam int unsigned SETTLE_CYCLES = 12;
    // ~1000 items at their worst pace, taken many times over
    localparam int unsigned LIMIT_CYCLES  = 1000000;

    typedef struct packed {
        logic [satq_pkg::SUM_W-1:0] sum;
        satq_pkg::status_t          status;
    } rect_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // element_value[15:0], top_row[21:16], left_column[27:22],
    // bottom_row[33:28], right_column[39:34]
    logic [satq_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    // operation[0]
    logic                            s_tuser = satq_pkg::OP_LOAD;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // rectangle_sum[27:0], zero pad[31:28]
    logic [satq_pkg::OUT_DATA_W-1:0] m_tdata;
    // status[1:0]
    logic [1:0]                      m_tuser;
    logic                            cfg_we = 1'b0;
    logic                            cfg_index = satq_pkg::REG_ROW_COUNT;
    logic [satq_pkg::COUNT_W-1:0]    cfg_data = '0;

    summed_area_table_query_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------------
    // behavioral integral table
    // ------------------------------------------------------------------------
    logic [satq_pkg::SUM_W-1:0]   sat_mem [MAX_R][MAX_C];
    logic [satq_pkg::COUNT_W-1:0] rows_reg;
    logic [satq_pkg::COUNT_W-1:0] cols_reg;
    int unsigned                  fill_row;
    int unsigned                  fill_col;
    logic [satq_pkg::RUN_W-1:0]   row_sum;
    bit                           table_ready;

    rect_result_t                 queued_rect_sums[$];

    // bookkeeping
    int unsigned        items_sent;
    int unsigned        loads_sent;
    int unsigned        queries_sent;
    int unsigned        results_seen;
    int unsigned        status_seen[3];
    int unsigned        error_count;
    int unsigned        cycle_count;

    // idling controls, changed per phase
    bit                 src_gaps_on;
    bit                 sink_stalls_on;

    // a count of 0 acts as 1, anything above the table size as the table size
    function automatic int unsigned used_count(logic [satq_pkg::COUNT_W-1:0] raw,
                                               int unsigned lim);
        if (raw == 0)
            return 1;
        if (raw > lim)
            return lim;
        return 32'(raw);
    endfunction

    function automatic void restart_fill();
        fill_row    = 0;
        fill_col    = 0;
        row_sum     = '0;
        table_ready = 1'b0;
    endfunction

    // border-shifted read: index 0 is the zero row/column above/left of the table
    function automatic logic [satq_pkg::SUM_W-1:0] sat_read(int unsigned r1, int unsigned c1);
        if (r1 == 0 || c1 == 0)
            return '0;
        return sat_mem[r1-1][c1-1];
    endfunction

    function automatic void sat_load_element(logic [satq_pkg::ELEM_W-1:0] elem);
        int unsigned                rows;
        int unsigned                cols;
        logic [satq_pkg::SUM_W-1:0] entry;
        rows = used_count(rows_reg, MAX_R);
        cols = used_count(cols_reg, MAX_C);
        // a load after a finished table starts a fresh one
        if (table_ready || fill_row >= rows || fill_col >= cols)
            restart_fill();
        row_sum = row_sum + {{(satq_pkg::RUN_W-satq_pkg::ELEM_W){elem[satq_pkg::ELEM_W-1]}},
                             elem};
        entry   = {{(satq_pkg::SUM_W-satq_pkg::RUN_W){row_sum[satq_pkg::RUN_W-1]}}, row_sum}
                + sat_read(fill_row, fill_col + 1);
        sat_mem[fill_row][fill_col] = entry;
        fill_col++;
        if (fill_col >= cols)
        begin
            fill_col = 0;
            row_sum  = '0;
            fill_row++;
            if (fill_row >= rows)
            begin
                fill_row    = 0;
                table_ready = 1'b1;
            end
        end
    endfunction

    function automatic rect_result_t sat_query_rect(int unsigned t, int unsigned l,
                                                    int unsigned b, int unsigned r);
        rect_result_t res;
        res.sum = '0;
        if (!table_ready)
            res.status = satq_pkg::STATUS_NOT_LOADED;
        else if (t > b || l > r || b >= used_count(rows_reg, MAX_R)
                 || r >= used_count(cols_reg, MAX_C))
            res.status = satq_pkg::STATUS_BAD_BOUNDS;
        else
        begin
            res.sum = sat_read(b + 1, r + 1) - sat_read(t, r + 1)
                    - sat_read(b + 1, l) + sat_read(t, l);
            res.status = satq_pkg::STATUS_OK;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t: run stopped at cycle limit, %0d results still due",
                     $time, queued_rect_sums.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result side: back-pressure and checking
    // ------------------------------------------------------------------------
    function automatic int unsigned draw_idle_len();
        // mostly short, now and then a long one
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial
    begin : sink_pacing
        int unsigned run_len;
        @(posedge rst_n);
        forever
        begin
            if (!sink_stalls_on)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                run_len = $urandom_range(1, 8);
                m_tready <= 1'b1;
                repeat (run_len) @(posedge clk);
                run_len = draw_idle_len();
                m_tready <= 1'b0;
                repeat (run_len) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        rect_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tuser <= satq_pkg::STATUS_BAD_BOUNDS)
                status_seen[m_tuser]++;
            if (queued_rect_sums.size() == 0)
            begin
                error_count++;
                $display("%0t: result with nothing expected, got sum %0d status %0d",
                         $time, $signed(m_tdata[satq_pkg::SUM_W-1:0]), m_tuser);
            end
            else
            begin
                want = queued_rect_sums.pop_front();
                if (m_tdata[satq_pkg::SUM_W-1:0] !== want.sum || m_tuser !== want.status)
                begin
                    error_count++;
                    $display("%0t: mismatch, expected sum %0d status %0d, got sum %0d status %0d",
                             $time, $signed(want.sum), want.status,
                             $signed(m_tdata[satq_pkg::SUM_W-1:0]), m_tuser);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    function automatic int unsigned draw_gap();
        if (!src_gaps_on || $urandom_range(0, 99) < 55)
            return 0;
        return draw_idle_len();
    endfunction

    // valid stays high on return; the next call or wait_block_idle decides
    // whether it drops, so it never gets two updates in one step
    task automatic send_item(logic op, logic [satq_pkg::ELEM_W-1:0] elem,
                             logic [satq_pkg::POS_W-1:0] t, logic [satq_pkg::POS_W-1:0] l,
                             logic [satq_pkg::POS_W-1:0] b, logic [satq_pkg::POS_W-1:0] r);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {r, b, l, t, elem};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        if (op == satq_pkg::OP_LOAD)
        begin
            loads_sent++;
            sat_load_element(elem);
        end
        else
        begin
            queries_sent++;
            queued_rect_sums = {queued_rect_sums,
                                sat_query_rect(32'(t), 32'(l), 32'(b), 32'(r))};
        end
    endtask

    // corner fields of a load are don't-care, so they carry noise
    task automatic load_element(logic [satq_pkg::ELEM_W-1:0] elem);
        send_item(satq_pkg::OP_LOAD, elem,
                  satq_pkg::POS_W'($urandom), satq_pkg::POS_W'($urandom),
                  satq_pkg::POS_W'($urandom), satq_pkg::POS_W'($urandom));
    endtask

    task automatic query_rect(int unsigned t, int unsigned l, int unsigned b, int unsigned r);
        send_item(satq_pkg::OP_QUERY, satq_pkg::ELEM_W'($urandom),
                  satq_pkg::POS_W'(t), satq_pkg::POS_W'(l),
                  satq_pkg::POS_W'(b), satq_pkg::POS_W'(r));
    endtask

    function automatic logic [satq_pkg::ELEM_W-1:0] draw_element();
        unique case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return satq_pkg::ELEM_W'($urandom);
        endcase
    endfunction

    // a rectangle inside the table in use
    task automatic query_good_rect();
        int unsigned t;
        int unsigned l;
        int unsigned b;
        int unsigned r;
        t = $urandom_range(0, used_count(rows_reg, MAX_R) - 1);
        b = $urandom_range(t, used_count(rows_reg, MAX_R) - 1);
        l = $urandom_range(0, used_count(cols_reg, MAX_C) - 1);
        r = $urandom_range(l, used_count(cols_reg, MAX_C) - 1);
        query_rect(t, l, b, r);
    endtask

    task automatic query_noise();
        query_rect($urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 63));
    endtask

    task automatic wait_block_idle();
        s_tvalid <= 1'b0;
        while (queued_rect_sums.size() != 0) @(posedge clk);
        // loads give no result, so let the last one finish its write
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // caller makes sure the block is idle
    task automatic write_count_reg(logic idx, logic [satq_pkg::COUNT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == satq_pkg::REG_ROW_COUNT)
            rows_reg = val;
        else
            cols_reg = val;
        restart_fill();
        @(posedge clk);
    endtask

    task automatic set_geometry(logic [satq_pkg::COUNT_W-1:0] rows_raw,
                                logic [satq_pkg::COUNT_W-1:0] cols_raw);
        wait_block_idle();
        if ($urandom_range(0, 1))
        begin
            write_count_reg(satq_pkg::REG_ROW_COUNT, rows_raw);
            write_count_reg(satq_pkg::REG_COLUMN_COUNT, cols_raw);
        end
        else
        begin
            write_count_reg(satq_pkg::REG_COLUMN_COUNT, cols_raw);
            write_count_reg(satq_pkg::REG_ROW_COUNT, rows_raw);
        end
    endtask

    task automatic fill_table(int unsigned noise_pct);
        int unsigned cells;
        cells = used_count(rows_reg, MAX_R) * used_count(cols_reg, MAX_C);
        repeat (cells)
        begin
            // queries mixed into the load see an incomplete table
            if ($urandom_range(0, 99) < noise_pct)
                query_noise();
            load_element(draw_element());
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // default 64x64 geometry, nothing loaded yet
    task automatic test_query_before_load();
        query_rect(0, 0, 63, 63);
        query_rect(63, 63, 0, 0);
    endtask

    // 2x3 table with extreme elements, every status and each bounds error
    task automatic test_small_table();
        set_geometry(2, 3);
        load_element(16'h7FFF);
        load_element(16'h8000);
        load_element(16'hFFFF);
        query_rect(0, 0, 0, 0);      // half loaded
        load_element(16'h0001);
        load_element(16'h0000);
        load_element(16'h1234);
        query_rect(0, 0, 1, 2);
        query_rect(1, 2, 1, 2);
        query_rect(0, 1, 1, 1);
        query_rect(1, 0, 0, 0);      // top below bottom
        query_rect(0, 2, 1, 1);      // left right of right
        query_rect(0, 0, 2, 0);      // bottom past rows in use
        query_rect(0, 0, 0, 3);      // right past columns in use
        query_rect(63, 63, 63, 63);
    endtask

    // a count write drops a half-built table, a load after completion too
    task automatic test_restart();
        set_geometry(2, 3);
        load_element(draw_element());
        load_element(draw_element());
        wait_block_idle();
        write_count_reg(satq_pkg::REG_COLUMN_COUNT, 3);
        query_rect(0, 0, 0, 0);
        fill_table(0);
        query_rect(0, 0, 1, 2);
        load_element(draw_element());
        query_rect(0, 0, 1, 2);
        fill_table(0);
        query_rect(1, 1, 1, 2);
    endtask

    // zero acts as one, oversized counts act as the table size
    task automatic test_count_clamp();
        set_geometry(0, 127);
        fill_table(0);
        query_rect(0, 0, 0, 63);
        query_rect(0, 63, 0, 63);
        query_rect(0, 17, 0, 42);
        query_rect(0, 0, 1, 0);
        set_geometry(65, 0);
        fill_table(0);
        query_rect(0, 0, 63, 0);
        query_rect(63, 0, 63, 0);
        query_rect(0, 0, 0, 1);
    endtask

    task automatic test_random_tables();
        int unsigned                  start_items;
        int unsigned                  pick;
        logic [satq_pkg::COUNT_W-1:0] rows_raw;
        logic [satq_pkg::COUNT_W-1:0] cols_raw;
        logic [satq_pkg::COUNT_W-1:0] wide_raw;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                rows_raw = satq_pkg::COUNT_W'($urandom_range(1, 8));
                cols_raw = satq_pkg::COUNT_W'($urandom_range(1, 8));
            end
            else
            begin
                // one long side, the other kept tiny to bound the load time
                if (pick < 90)
                    wide_raw = satq_pkg::COUNT_W'($urandom_range(9, 64));
                else
                    wide_raw = ($urandom_range(0, 4) == 0) ? 7'd0
                             : satq_pkg::COUNT_W'($urandom_range(65, 127));
                if ($urandom_range(0, 1))
                begin
                    rows_raw = wide_raw;
                    cols_raw = satq_pkg::COUNT_W'($urandom_range(0, 3));
                end
                else
                begin
                    rows_raw = satq_pkg::COUNT_W'($urandom_range(0, 3));
                    cols_raw = wide_raw;
                end
            end
            set_geometry(rows_raw, cols_raw);
            src_gaps_on    = $urandom_range(0, 3) != 0;
            sink_stalls_on = $urandom_range(0, 3) != 0;

            fill_table(4);
            repeat ($urandom_range(3, 10))
            begin
                if ($urandom_range(0, 99) < 75)
                    query_good_rect();
                else
                    query_noise();
            end

            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                // a new table started and left unfinished
                repeat ($urandom_range(1, 6)) load_element(draw_element());
                query_good_rect();
            end
            else if (pick < 20)
            begin
                // rewriting a register with its own value still restarts
                wait_block_idle();
                write_count_reg(satq_pkg::REG_ROW_COUNT, rows_reg);
                query_good_rect();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rows_reg = 7'd64;
        cols_reg = 7'd64;
        restart_fill();
        for (int i = 0; i < MAX_R; i++)
            for (int j = 0; j < MAX_C; j++)
                sat_mem[i][j] = '0;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_query_before_load();
        test_small_table();
        test_restart();
        test_count_clamp();
        test_random_tables();

        wait_block_idle();
        $display("%0d loads and %0d queries sent, %0d results checked",
                 loads_sent, queries_sent, results_seen);
        $display("statuses seen: %0d ok, %0d table not loaded, %0d bad bounds",
                 status_seen[satq_pkg::STATUS_OK], status_seen[satq_pkg::STATUS_NOT_LOADED],
                 status_seen[satq_pkg::STATUS_BAD_BOUNDS]);
        if (error_count == 0 && queued_rect_sums.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
